FILE: sv/kvlp_pkg.sv
// Shared types and constants for the key/value line parser.
`timescale 1ns / 1ps

package kvlp_pkg;

    localparam int KEY_WIDTH_DEF = 32;
    localparam int KEY_OUT_W     = 32;

    // Result queue geometry
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       byte_present;
        logic       line_end;
    } in_word_t;

    typedef struct packed {
        logic                        value_valid;
        logic [7:0]                  out_byte;
        logic                        record_done;
        logic signed [KEY_OUT_W-1:0] parsed_key;
        logic                        parse_status;
    } out_word_t;

    // Results of one processed word, value byte first
    typedef struct packed {
        logic      byte_push;
        out_word_t byte_word;
        logic      rec_push;
        out_word_t rec_word;
    } parse_res_t;

endpackage

FILE: sv/key_value_line_parser_core.sv
// Top level of the key/value line parser: input register, parser, result queue.
`timescale 1ns / 1ps
// Path: an accepted word is held in the input register, parsed from there once the
//   result queue has room, and its results are written into the queue that drives m_.
// Throughput: one word per cycle while the queue has room; a line-closing word with a value byte yields two
//   results, drained one per cycle while m_ready is high; the held word waits while the four-entry queue
//   holds more than two results.
// Reset: synchronous, active-low aresetn empties both stages and restarts the line.

module key_value_line_parser_core import kvlp_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    // Input register stage
    logic       in_valid_reg, in_valid_next;
    in_word_t   in_word_reg;
    logic       space_ok;
    logic       proc_fire;
    logic       s_take;
    parse_res_t res;

    // Process the held word once the queue can absorb both possible results.
    assign proc_fire = in_valid_reg && space_ok;

    // Take a new word when the register is empty or is being drained now,
    // so a steady stream moves one word per cycle.
    assign s_ready = !in_valid_reg || space_ok;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload: load on acceptance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_word_reg <= s_word;
        end
    end

    // Parser: state update and result words for the held word
    kvlp_parse #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .in_word (in_word_reg),
        .res     (res)
    );

    // Result queue: decouples the output handshake from parsing
    kvlp_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word)
    );

endmodule

FILE: sv/kvlp_parse.sv
// Parser state registers and the per-word next-state and result logic.
`timescale 1ns / 1ps

module kvlp_parse import kvlp_pkg::*; #(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  in_word_t   in_word,
    output parse_res_t res
);

    localparam logic [2:0] PH_LEAD    = 3'd0;
    localparam logic [2:0] PH_KEY     = 3'd1;
    localparam logic [2:0] PH_SEEK    = 3'd2;
    localparam logic [2:0] PH_POST    = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_END_OK  = 3'd5;
    localparam logic [2:0] PH_END_ERR = 3'd6;

    logic [2:0]           phase_reg, phase_next, phase_upd;
    logic [KEY_WIDTH-1:0] key_reg, key_next, key_upd;
    logic                 neg_reg, neg_next, neg_upd;
    logic [7:0]           delim_reg, delim_next, delim_upd;

    logic [7:0]           c;
    logic                 is_ws, is_digit, emit;
    logic [2:0]           seek_phase;
    logic [7:0]           delim_eff;
    logic                 val_term;
    logic [KEY_WIDTH-1:0] key_digit, key_times10, key_fin;
    logic [KEY_OUT_W-1:0] key_out;
    logic                 status;

    assign c           = in_word.line_byte;
    assign is_ws       = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign key_digit   = {{(KEY_WIDTH-4){1'b0}}, c[3:0]};
    assign key_times10 = (key_reg << 3) + (key_reg << 1);
    assign seek_phase  = (c == CH_COMMA) ? PH_POST :
                         (c == CH_NUL)   ? PH_END_ERR : PH_SEEK;
    // An unquoted value always ends at newline
    assign delim_eff   = (phase_reg == PH_POST) ? CH_NL : delim_reg;
    assign val_term    = (c == CH_NUL) || (c == delim_eff);

    always_comb begin
        phase_upd = phase_reg;
        key_upd   = key_reg;
        neg_upd   = neg_reg;
        delim_upd = delim_reg;
        emit      = 1'b0;
        if (in_word.byte_present) begin
            case (phase_reg)
                PH_LEAD: begin
                    if (is_ws) begin
                        phase_upd = PH_LEAD;
                    end else if (c == CH_MINUS) begin
                        neg_upd   = 1'b1;
                        phase_upd = PH_KEY;
                    end else if (c == CH_PLUS) begin
                        phase_upd = PH_KEY;
                    end else if (is_digit) begin
                        key_upd   = key_digit;
                        phase_upd = PH_KEY;
                    end else begin
                        phase_upd = seek_phase;
                    end
                end
                PH_KEY: begin
                    if (is_digit) begin
                        key_upd = key_times10 + key_digit;
                    end else begin
                        phase_upd = seek_phase;
                    end
                end
                PH_SEEK: begin
                    phase_upd = seek_phase;
                end
                PH_POST: begin
                    if ((c == CH_SPACE) || (c == CH_TAB)) begin
                        phase_upd = PH_POST;
                    end else if (c == CH_NUL) begin
                        phase_upd = PH_END_OK;
                    end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                        delim_upd = c;
                        phase_upd = PH_VALUE;
                    end else begin
                        delim_upd = CH_NL;
                        phase_upd = val_term ? PH_END_OK : PH_VALUE;
                        emit      = !val_term;
                    end
                end
                PH_VALUE: begin
                    phase_upd = val_term ? PH_END_OK : PH_VALUE;
                    emit      = !val_term;
                end
                PH_END_OK, PH_END_ERR: begin
                    phase_upd = phase_reg;
                end
                default: begin
                    phase_upd = PH_END_ERR;
                end
            endcase
        end
    end

    // Line end closes the record and restarts the line
    always_comb begin
        if (in_word.line_end) begin
            phase_next = PH_LEAD;
            key_next   = '0;
            neg_next   = 1'b0;
            delim_next = CH_NL;
        end else begin
            phase_next = phase_upd;
            key_next   = key_upd;
            neg_next   = neg_upd;
            delim_next = delim_upd;
        end
    end

    assign key_fin = neg_upd ? ('0 - key_upd) : key_upd;

    generate
        if (KEY_WIDTH >= KEY_OUT_W) begin : g_key_trunc
            assign key_out = key_fin[KEY_OUT_W-1:0];
        end else begin : g_key_sext
            assign key_out = {{(KEY_OUT_W-KEY_WIDTH){key_fin[KEY_WIDTH-1]}}, key_fin};
        end
    endgenerate

    assign status = (phase_upd == PH_LEAD) || (phase_upd == PH_KEY) ||
                    (phase_upd == PH_SEEK) || (phase_upd == PH_END_ERR);

    always_comb begin
        res                        = '0;
        res.byte_push              = fire && emit;
        res.byte_word.value_valid  = 1'b1;
        res.byte_word.out_byte     = c;
        res.rec_push               = fire && in_word.line_end;
        res.rec_word.record_done   = 1'b1;
        res.rec_word.parsed_key    = key_out;
        res.rec_word.parse_status  = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            key_reg   <= '0;
            neg_reg   <= 1'b0;
            delim_reg <= CH_NL;
        end else if (fire) begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            neg_reg   <= neg_next;
            delim_reg <= delim_next;
        end
    end

    a_line_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_word.line_end |=> phase_reg == PH_LEAD && key_reg == '0 && !neg_reg)
        else $error("parser state not restarted after line end");

    a_emit_in_value: assert property (@(posedge aclk) disable iff (!aresetn)
        res.byte_push |-> phase_reg == PH_POST || phase_reg == PH_VALUE)
        else $error("value byte emitted outside the value phases");

endmodule

FILE: sv/kvlp_result_fifo.sv
// Small result queue: takes up to two words a cycle, hands out one.
`timescale 1ns / 1ps

module kvlp_result_fifo import kvlp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  parse_res_t res,
    output logic       space_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_word
);

    out_word_t            mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_PTR_W-1:0] idx_b;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n   = {1'b0, res.byte_push} + {1'b0, res.rec_push};
    assign pop      = m_valid && m_ready;
    assign idx_b    = res.byte_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign space_ok = count_reg <= RES_CNT_W'(RES_DEPTH - 2);
    assign m_valid  = count_reg != '0;
    assign m_word   = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
    assign count_next  = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (res.byte_push) begin
            mem_reg[wr_ptr_reg] <= res.byte_word;
        end
        if (res.rec_push) begin
            mem_reg[idx_b] <= res.rec_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.byte_push || res.rec_push) |-> space_ok)
        else $error("result pushed without two free entries");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the key/value line parser core.
`timescale 1ns / 1ps

module tb;
    import kvlp_pkg::*;

    localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the pressure test

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        P_LEAD,
        P_KEY,
        P_SEEK,
        P_POST,
        P_VALUE,
        P_END_OK,
        P_END_ERR
    } parse_phase_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // Predictor state: mirrors the parser's line state
    parse_phase_t phase;
    logic [31:0]  key_acc;
    logic         key_neg;
    logic [7:0]   value_delim;

    out_word_t   expected_words[$];   // results still owed by the block, oldest first
    logic [7:0]  line_bytes[$];       // text of the line being sent
    out_word_t   want;
    int          err_cnt    = 0;
    int          items_sent = 0;      // words that the block does not ignore
    bit          idle_on    = 1'b1;   // random gaps on both sides
    logic        hold_req   = 1'b0;   // ask the receiver for a long hold-off

    key_value_line_parser_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Generous run limit; a hang anywhere ends here
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_line_state();
        phase       = P_LEAD;
        key_acc     = '0;
        key_neg     = 1'b0;
        value_delim = CH_NL;
    endfunction

    // Byte outside the key: hunt for the comma or the end of text
    function automatic void hunt_comma(logic [7:0] c);
        if (c == CH_COMMA)
            phase = P_POST;
        else if (c == CH_NUL)
            phase = P_END_ERR;
        else
            phase = P_SEEK;
    endfunction

    // Value byte: returns 1 if it goes out as a result
    function automatic bit take_value_byte(logic [7:0] c);
        if (c == CH_NUL || c == value_delim) begin
            phase = P_END_OK;
            return 1'b0;
        end
        phase = P_VALUE;
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted word and queue the results it owes
    function automatic void parse_word(in_word_t w);
        out_word_t   r;
        logic [7:0]  c;
        logic [31:0] k;
        bit          emit;
        c    = w.line_byte;
        emit = 1'b0;
        if (w.byte_present) begin
            case (phase)
                P_LEAD: begin
                    if (is_space(c)) begin
                        // hold
                    end else if (c == CH_MINUS) begin
                        key_neg = 1'b1;
                        phase   = P_KEY;
                    end else if (c == CH_PLUS) begin
                        phase = P_KEY;
                    end else if (is_digit(c)) begin
                        key_acc = 32'(c - CH_ZERO);
                        phase   = P_KEY;
                    end else begin
                        hunt_comma(c);
                    end
                end
                P_KEY: begin
                    if (is_digit(c))
                        key_acc = key_acc * 32'd10 + 32'(c - CH_ZERO);
                    else
                        hunt_comma(c);
                end
                P_SEEK: hunt_comma(c);
                P_POST: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        // hold
                    end else if (c == CH_NUL) begin
                        phase = P_END_OK;
                    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                        value_delim = c;
                        phase       = P_VALUE;
                    end else begin
                        value_delim = CH_NL;
                        emit        = take_value_byte(c);
                    end
                end
                P_VALUE: emit = take_value_byte(c);
                P_END_OK, P_END_ERR: ;
                default: phase = P_END_ERR;
            endcase
            if (emit) begin
                r             = '0;
                r.value_valid = 1'b1;
                r.out_byte    = c;
                expected_words.push_back(r);
            end
        end
        if (w.line_end) begin
            k              = key_neg ? -key_acc : key_acc;
            r              = '0;
            r.record_done  = 1'b1;
            r.parsed_key   = k;
            r.parse_status = (phase inside {P_LEAD, P_KEY, P_SEEK, P_END_ERR});
            expected_words.push_back(r);
            clear_line_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: compare every accepted result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result with nothing expected: %p", m_word);
                err_cnt++;
            end else begin
                want = expected_words.pop_front();
                if (m_word.value_valid !== want.value_valid) begin
                    $error("value_valid: expected %0d, got %0d",
                           want.value_valid, m_word.value_valid);
                    err_cnt++;
                end
                if (m_word.out_byte !== want.out_byte) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h",
                           want.out_byte, m_word.out_byte);
                    err_cnt++;
                end
                if (m_word.record_done !== want.record_done) begin
                    $error("record_done: expected %0d, got %0d",
                           want.record_done, m_word.record_done);
                    err_cnt++;
                end
                if (m_word.parsed_key !== want.parsed_key) begin
                    $error("parsed_key: expected %0d, got %0d",
                           want.parsed_key, m_word.parsed_key);
                    err_cnt++;
                end
                if (m_word.parse_status !== want.parse_status) begin
                    $error("parse_status: expected %0d, got %0d",
                           want.parse_status, m_word.parse_status);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per result, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                // Drop ready and count out the hold-off here, not in the sender
                m_ready  <= 1'b0;
                hold_req <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !hold_req);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic in_word_t make_word(logic [7:0] b, logic present, logic last);
        in_word_t w;
        w.line_byte    = b;
        w.byte_present = present;
        w.line_end     = last;
        return w;
    endfunction

    // Offer one word after a random gap; hold it until accepted, then predict
    task automatic send_word(in_word_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        parse_word(w);
        if (w.byte_present || w.line_end)
            items_sent++;
    endtask

    // Send line_bytes; close the line on the last byte or with a bare end marker
    task automatic send_line(bit bare_end, bit with_blanks);
        int last;
        last = line_bytes.size() - 1;
        if (line_bytes.size() == 0)
            bare_end = 1'b1;
        foreach (line_bytes[i]) begin
            if (with_blanks && $urandom_range(0, 15) == 0)
                send_word(make_word(8'($urandom), 1'b0, 1'b0));
            send_word(make_word(line_bytes[i], 1'b1, !bare_end && i == last));
        end
        if (bare_end)
            send_word(make_word(8'($urandom), 1'b0, 1'b1));
        line_bytes.delete();
    endtask

    task automatic add_text(string s);
        foreach (s[i]) line_bytes.push_back(s[i]);
    endtask

    // Nonzero byte other than the one to avoid
    function automatic logic [7:0] text_byte(logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == avoid);
        return b;
    endfunction

    // Random byte biased toward the characters the parser reacts to
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return CH_NUL;
            1: return CH_COMMA;
            2: return CH_SQUOTE;
            3: return CH_DQUOTE;
            4: return CH_NL;
            5: return CH_SPACE;
            6: return CH_MINUS;
            7: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] blank_byte();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    // Well-formed record line with random content
    task automatic gen_record_line();
        int         n;
        int         kind;
        logic [7:0] delim;
        repeat ($urandom_range(0, 2))
            line_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                 8'($urandom_range(9, 13)) : blank_byte());
        case ($urandom_range(0, 3))
            0: line_bytes.push_back(CH_MINUS);
            1: line_bytes.push_back(CH_PLUS);
            default: ;
        endcase
        // Mostly short keys; now and then long enough to wrap
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        repeat (n) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_bytes.push_back(text_byte(CH_COMMA));
        line_bytes.push_back(CH_COMMA);
        repeat ($urandom_range(0, 2)) line_bytes.push_back(blank_byte());
        kind  = $urandom_range(0, 3);
        delim = (kind == 0) ? CH_SQUOTE : (kind == 1) ? CH_DQUOTE : CH_NL;
        if (kind < 2)
            line_bytes.push_back(delim);
        if (kind != 3) begin
            repeat ($urandom_range(0, 8)) line_bytes.push_back(text_byte(delim));
            if ($urandom_range(0, 3) != 0)
                line_bytes.push_back(delim);
            repeat ($urandom_range(0, 2)) line_bytes.push_back(noise_byte());
        end
    endtask

    task automatic gen_noise_line();
        repeat ($urandom_range(0, 16)) line_bytes.push_back(noise_byte());
    endtask

    task automatic send_random_lines(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0)
                gen_noise_line();
            else
                gen_record_line();
            send_line($urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short lines that hit the special cases one by one
    task automatic test_directed_lines();
        // Value byte on the closing word: two results from one word
        add_text("\t+9,");
        line_bytes.push_back(8'h80);
        send_line(1'b0, 1'b0);
        // Sign without digits, empty quoted value, bare end marker
        add_text("\v-,\"\"");
        send_line(1'b1, 1'b0);
        // Zero byte before the comma ends the text with an error
        add_text("x");
        line_bytes.push_back(CH_NUL);
        add_text(",");
        send_line(1'b0, 1'b0);
        // Key wraps; unclosed quote runs to line end
        add_text("-2147483649,'");
        line_bytes.push_back(8'hFF);
        send_line(1'b0, 1'b0);
        // Ignored empty word, then a line with nothing but the end marker
        send_word(make_word(8'hA5, 1'b0, 1'b0));
        send_word(make_word(8'h5A, 1'b0, 1'b1));
        // Newline right after the comma: empty value, rest ignored
        add_text("7 , \n1");
        send_line(1'b0, 1'b0);
        // Line ends while skipping blanks after the comma
        add_text("3, ");
        send_line(1'b0, 1'b0);
        // Zero byte inside the value ends it
        add_text("1,a");
        line_bytes.push_back(CH_NUL);
        add_text("b");
        send_line(1'b0, 1'b0);
    endtask

    task automatic test_random_traffic();
        idle_on = 1'b1;
        send_random_lines(850);
    endtask

    // Stretch with no gaps on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_random_lines(150);
        idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        hold_req <= 1'b1;
        send_random_lines(120);
        idle_on  = 1'b1;
    endtask

    // Stop offering and let every owed result come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    initial begin
        clear_line_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_lines();
        test_random_traffic();
        test_back_to_back();
        test_output_backpressure();
        drain_results();

        if (err_cnt == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
